// ===== design/ultrasonic_echo_ranger_core_defines.svh =====
// Assertion macros shared by the ranger RTL.
// ERC_ASSERT is disabled while reset is asserted; ERC_ASSERT_NR also checks during reset.
`ifndef ULTRASONIC_ECHO_RANGER_CORE_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define ERC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ERC_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ERC_ASSERT(lbl, prop, msg)
`define ERC_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ===== design/erc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package erc_pkg;

  localparam int unsigned SAMPLES    = 5;
  localparam int unsigned CM_DIVISOR = 58;

  localparam int unsigned TRIG_W    = 10;
  localparam int unsigned GAP_W     = 17;
  localparam int unsigned ECHO_W    = 16;
  localparam int unsigned SUM_W     = 19;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned DIST_W    = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 17;

  localparam logic [TRIG_W-1:0] TRIG_RESET  = 10'd20;
  localparam logic [GAP_W-1:0]  GAP_RESET   = 17'd50000;
  localparam logic [ECHO_W-1:0] LIMIT_RESET = 16'd65535;

  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Distance = (sum * 16) / (SAMPLES * 58). The division is an exact reciprocal
  // multiplication: with S = N + ceil(log2 D) and M = ceil(2^S / D), the error
  // M*D - 2^S stays below 2^(S-N), so floor(n*M / 2^S) = floor(n / D) for n < 2^N.
  localparam int unsigned     DIST_DIV  = SAMPLES * CM_DIVISOR;
  localparam int unsigned     NUM_W     = SUM_W + 4;
  localparam int unsigned     DIV_SHIFT = NUM_W + $clog2(DIST_DIV);
  localparam longint unsigned RECIP     =
      ((64'd1 << DIV_SHIFT) + DIST_DIV - 1) / DIST_DIV;
  localparam int unsigned     RECIP_W   = NUM_W + 1;
  localparam int unsigned     PROD_W    = SUM_W + RECIP_W;
  localparam int unsigned     QUO_SHIFT = DIV_SHIFT - 4;
  localparam int unsigned     QUO_W     = PROD_W - QUO_SHIFT;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_TRIG     = 3'd1,
    PH_WAIT     = 3'd2,
    PH_MEAS     = 3'd3,
    PH_GAP      = 3'd4,
    PH_GAP_LAST = 3'd5
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER    = 2'd0,
    CFG_GAP        = 2'd1,
    CFG_ECHO_LIMIT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [DIST_W-1:0] distance_q4;
    logic              result_valid;
    logic              busy_res;
    logic              trig_level;
  } result_t;

endpackage

`default_nettype wire

// ===== design/ultrasonic_echo_ranger_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "ultrasonic_echo_ranger_core_defines.svh"

// Averaged ultrasonic time-of-flight ranger. Every input request is one
// microsecond tick carrying a start request and the sampled echo pin level;
// every request yields exactly one result with the trigger pin level, a busy
// flag, a one-tick result valid and the averaged distance in sixteenths of a
// centimeter (the last value is held between results). The block takes one
// request per clock cycle: a request is captured in an input register, the
// sequencer and the reciprocal divider update the state in one pass, and the
// result is written into an output register when that pass fires. Input and
// output registers decouple the two streams, so throughput stays at one
// request per cycle as long as the result side keeps up. Configuration writes
// are taken in any cycle and are meant to happen while no sequence runs.
module ultrasonic_echo_ranger_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // tdata: [0] start_req, [1] echo_level, upper bits zero
  input  wire logic [erc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tdata: [0] trig_level, [1] busy_res, [2] result_valid, [17:3] distance_q4
  output logic [erc_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [erc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [erc_pkg::CFG_DAT_W-1:0]      cfg_data_i
);
  import erc_pkg::*;

  // Configuration registers
  logic [TRIG_W-1:0] trigger_us_q;
  logic [GAP_W-1:0]  gap_us_q;
  logic [ECHO_W-1:0] echo_limit_us_q;

  // Input register
  logic in_valid_q, in_valid_d;
  logic in_start_q, in_echo_q;

  // Sequencer state
  phase_e            phase_q, phase_d;
  logic [GAP_W-1:0]  phase_ticks_q, phase_ticks_d;
  logic [ECHO_W-1:0] echo_width_q, echo_width_d;
  logic [SUM_W-1:0]  width_sum_q, width_sum_d;
  logic [IDX_W-1:0]  sample_index_q, sample_index_d;
  logic [DIST_W-1:0] held_distance_q, held_distance_d;

  // Output register
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  logic s_accept, out_free, fire;
  logic result_valid;

  logic [GAP_W-1:0]  ticks_inc;
  logic              gap_done;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_sat;
  logic [IDX_W:0]    sample_next;
  logic              last_sample;
  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  quo;
  logic [DIST_W-1:0] distance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_us_q    <= TRIG_RESET;
      gap_us_q        <= GAP_RESET;
      echo_limit_us_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TRIGGER:    trigger_us_q    <= cfg_data_i[TRIG_W-1:0];
        CFG_GAP:        gap_us_q        <= cfg_data_i[GAP_W-1:0];
        CFG_ECHO_LIMIT: echo_limit_us_q <= cfg_data_i[ECHO_W-1:0];
        default:        ;
      endcase
    end
  end

  // Handshake: the pass fires when the input register holds a request and the
  // output register is empty or being drained this cycle.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Datapath helpers
  assign ticks_inc   = phase_ticks_q + GAP_W'(1);
  assign gap_done    = ticks_inc >= gap_us_q;
  assign sum_ext     = {1'b0, width_sum_q} + (SUM_W + 1)'(echo_width_q);
  assign sum_sat     = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
  assign sample_next = {1'b0, sample_index_q} + (IDX_W + 1)'(1);
  assign last_sample = sample_next >= (IDX_W + 1)'(SAMPLES);

  assign prod     = PROD_W'(width_sum_q) * PROD_W'(RECIP);
  assign quo      = prod[PROD_W-1:QUO_SHIFT];
  assign distance = (quo > QUO_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(quo);

  // Next state
  always_comb begin
    phase_d         = phase_q;
    phase_ticks_d   = phase_ticks_q;
    echo_width_d    = echo_width_q;
    width_sum_d     = width_sum_q;
    sample_index_d  = sample_index_q;
    held_distance_d = held_distance_q;
    result_valid    = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (in_start_q) begin
          width_sum_d    = '0;
          sample_index_d = '0;
          echo_width_d   = '0;
          phase_d        = PH_TRIG;
          phase_ticks_d  = GAP_W'(1);
        end
      end
      PH_TRIG: begin
        if (phase_ticks_q >= GAP_W'(trigger_us_q)) begin
          phase_d       = PH_WAIT;
          phase_ticks_d = '0;
        end else begin
          phase_ticks_d = ticks_inc;
        end
      end
      PH_WAIT: begin
        if (in_echo_q) begin
          echo_width_d = (echo_limit_us_q != '0) ? ECHO_W'(1) : '0;
          phase_d      = PH_MEAS;
        end
      end
      PH_MEAS: begin
        if (in_echo_q) begin
          if (echo_width_q >= echo_limit_us_q) begin
            echo_width_d = echo_limit_us_q;
          end else begin
            echo_width_d = echo_width_q + ECHO_W'(1);
          end
        end else begin
          width_sum_d    = sum_sat;
          phase_d        = last_sample ? PH_GAP_LAST : PH_GAP;
          sample_index_d = sample_next[IDX_W-1:0];
          phase_ticks_d  = '0;
        end
      end
      PH_GAP, PH_GAP_LAST: begin
        phase_ticks_d = ticks_inc;
        if (gap_done) begin
          if (phase_q == PH_GAP_LAST) begin
            held_distance_d = distance;
            result_valid    = 1'b1;
            phase_d         = PH_IDLE;
            phase_ticks_d   = '0;
          end else begin
            phase_d       = PH_TRIG;
            phase_ticks_d = GAP_W'(1);
          end
        end
      end
      default: begin
        phase_d       = PH_IDLE;
        phase_ticks_d = '0;
      end
    endcase
  end

  // Result fields show the state after this tick.
  always_comb begin
    out_d.trig_level   = (phase_d == PH_TRIG);
    out_d.busy_res     = (phase_d != PH_IDLE);
    out_d.result_valid = result_valid;
    out_d.distance_q4  = held_distance_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      phase_q         <= PH_IDLE;
      phase_ticks_q   <= '0;
      echo_width_q    <= '0;
      width_sum_q     <= '0;
      sample_index_q  <= '0;
      held_distance_q <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        phase_q         <= phase_d;
        phase_ticks_q   <= phase_ticks_d;
        echo_width_q    <= echo_width_d;
        width_sum_q     <= width_sum_d;
        sample_index_q  <= sample_index_d;
        held_distance_q <= held_distance_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_start_q <= s_axis_tdata[0];
      in_echo_q  <= s_axis_tdata[1];
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_q);

  `ERC_ASSERT_NR(a_trig_implies_busy,
    (m_axis_tvalid && out_q.trig_level) |-> out_q.busy_res,
    "Trigger driven while the result reports idle")
  `ERC_ASSERT(a_distance_from_last_gap,
    (held_distance_q != $past(held_distance_q)) |-> ($past(phase_q) == PH_GAP_LAST),
    "Held distance changed outside the end of the final pause")
  `ERC_ASSERT(a_last_gap_count,
    (phase_q == PH_GAP_LAST) |-> (sample_index_q == IDX_W'(SAMPLES)),
    "Final pause entered with a wrong sample count")
  `ERC_ASSERT(a_mid_gap_count,
    (phase_q == PH_GAP) |-> ({1'b0, sample_index_q} < (IDX_W + 1)'(SAMPLES)),
    "Intermediate pause after the last sample")

endmodule

`default_nettype wire
